### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) (prop)) \
      else $error("assertion failed");

`endif

### rtl/bfpe_pkg.sv
// ----------------------------------------------------------------------------
// bfpe_pkg
// Shared types and constants of the byte frame pulse encoder.
// ----------------------------------------------------------------------------
package bfpe_pkg;

   localparam int PREFIX_MAX_BITS  = 8;
   localparam int POSTFIX_MAX_BITS = 8;
   localparam int PATTERN_BITS     = 8;
   localparam int DATA_BITS        = 8;
   localparam int MAX_RESULTS      = 50;
   localparam int CNT_W            = $clog2(MAX_RESULTS + 1);

   localparam int PULSE_W = 16;
   localparam int DUR_W   = 15;
   localparam int PAIR_W  = 2 * PULSE_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_PATTERN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTFIX_PATTERN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POSTFIX_LENGTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_MODE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSES_ONE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSES_ZERO     = 3'd6;

   localparam logic [1:0] PAR_NONE = 2'd0;
   localparam logic [1:0] PAR_EVEN = 2'd1;

   typedef struct packed {
      logic             level;
      logic [DUR_W-1:0] duration;
      logic             last;
   } bfpe_pulse_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } bfpe_state_type;

endpackage

### rtl/bfpe_queue.sv
// ----------------------------------------------------------------------------
// bfpe_queue
// Two-entry queue built from a head and a tail register.
// ----------------------------------------------------------------------------
module bfpe_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [1:0]       cnt_ff, cnt_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign dout    = head_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      cnt_in  = cnt_ff + 2'(do_push) - 2'(do_pop);
      tail_in = do_push ? din : tail_ff;
      head_in = head_ff;
      if (do_pop) begin
         head_in = (cnt_ff == 2'd2) ? tail_ff : din;
      end else if (cnt_ff == 2'd0) begin
         head_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

### rtl/bfpe_front.sv
// ----------------------------------------------------------------------------
// bfpe_front
// Builds the frame bit string and its length for one data byte.
// ----------------------------------------------------------------------------
module bfpe_front #(
   parameter int PREFIX_MAX_BITS  = bfpe_pkg::PREFIX_MAX_BITS,
   parameter int POSTFIX_MAX_BITS = bfpe_pkg::POSTFIX_MAX_BITS,
   parameter int FRAME_W = PREFIX_MAX_BITS + bfpe_pkg::DATA_BITS + 1 + POSTFIX_MAX_BITS,
   parameter int LEN_W   = $clog2(FRAME_W + 1)
) (
   input  logic [bfpe_pkg::PATTERN_BITS-1:0] prefix_pattern,
   input  logic [3:0]                        prefix_length,
   input  logic [bfpe_pkg::PATTERN_BITS-1:0] postfix_pattern,
   input  logic [3:0]                        postfix_length,
   input  logic [2:0]                        frame_mode,
   input  logic                              req_push,
   input  logic [bfpe_pkg::DATA_BITS-1:0]    req_data_byte,
   output logic                              req_full,
   output logic                              mid_push,
   output logic [FRAME_W-1:0]                mid_bits,
   output logic [LEN_W-1:0]                  mid_len,
   input  logic                              mid_full
);

   localparam int PRE_CNT_W  = $clog2(PREFIX_MAX_BITS + 1);
   localparam int POST_CNT_W = $clog2(POSTFIX_MAX_BITS + 1);

   logic [PRE_CNT_W-1:0]                  pre_n;
   logic [POST_CNT_W-1:0]                 post_n;
   logic [PREFIX_MAX_BITS+7:0]            pre_ext;
   logic [POSTFIX_MAX_BITS+7:0]           post_ext;
   logic [PREFIX_MAX_BITS-1:0]            pre_bits;
   logic [POSTFIX_MAX_BITS-1:0]           post_bits;
   logic [bfpe_pkg::DATA_BITS-1:0]        data_ord;
   logic [1:0]                            par_mode;
   logic                                  has_par;
   logic                                  par_bit;
   logic [LEN_W-1:0]                      data_sh, par_sh, post_sh;

   assign req_full = mid_full;
   assign mid_push = req_push;

   always_comb begin
      pre_n  = (int'(prefix_length) > PREFIX_MAX_BITS) ?
               PRE_CNT_W'(PREFIX_MAX_BITS) : PRE_CNT_W'(prefix_length);
      post_n = (int'(postfix_length) > POSTFIX_MAX_BITS) ?
               POST_CNT_W'(POSTFIX_MAX_BITS) : POST_CNT_W'(postfix_length);
      pre_ext  = (PREFIX_MAX_BITS + 8)'(prefix_pattern);
      post_ext = (POSTFIX_MAX_BITS + 8)'(postfix_pattern);
      for (int i = 0; i < PREFIX_MAX_BITS; i++) begin
         pre_bits[i] = pre_ext[i] && (i < int'(pre_n));
      end
      for (int i = 0; i < POSTFIX_MAX_BITS; i++) begin
         post_bits[i] = post_ext[i] && (i < int'(post_n));
      end
      for (int i = 0; i < bfpe_pkg::DATA_BITS; i++) begin
         data_ord[i] = frame_mode[0] ? req_data_byte[bfpe_pkg::DATA_BITS-1-i]
                                     : req_data_byte[i];
      end
      par_mode = frame_mode[2:1];
      has_par  = (par_mode != bfpe_pkg::PAR_NONE);
      par_bit  = (par_mode == bfpe_pkg::PAR_EVEN) ? (^req_data_byte) : !(^req_data_byte);

      data_sh = LEN_W'(pre_n);
      par_sh  = data_sh + LEN_W'(bfpe_pkg::DATA_BITS);
      post_sh = par_sh + LEN_W'(has_par);
      mid_len = post_sh + LEN_W'(post_n);

      mid_bits = FRAME_W'(pre_bits)
               | (FRAME_W'(data_ord) << data_sh)
               | (FRAME_W'(par_bit && has_par) << par_sh)
               | (FRAME_W'(post_bits) << post_sh);
   end

endmodule

### rtl/bfpe_back.sv
// ----------------------------------------------------------------------------
// bfpe_back
// Walks one frame bit string and issues one pulse per cycle while the output
// queue has room. One pulse is held back so the last of the frame is flagged.
// ----------------------------------------------------------------------------
module bfpe_back #(
   parameter int PREFIX_MAX_BITS  = bfpe_pkg::PREFIX_MAX_BITS,
   parameter int POSTFIX_MAX_BITS = bfpe_pkg::POSTFIX_MAX_BITS,
   parameter int FRAME_W = PREFIX_MAX_BITS + bfpe_pkg::DATA_BITS + 1 + POSTFIX_MAX_BITS,
   parameter int LEN_W   = $clog2(FRAME_W + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bfpe_pkg::PAIR_W-1:0]     pulses_for_one,
   input  logic [bfpe_pkg::PAIR_W-1:0]     pulses_for_zero,
   input  logic                            mid_empty,
   input  logic [FRAME_W-1:0]              mid_bits,
   input  logic [LEN_W-1:0]                mid_len,
   output logic                            mid_pop,
   input  logic                            out_full,
   output logic                            out_push,
   output bfpe_pkg::bfpe_pulse_type        out_data
);

   bfpe_pkg::bfpe_state_type state_ff, state_in;

   logic [FRAME_W-1:0]                bits_ff, bits_in;
   logic [LEN_W-1:0]                  rem_ff, rem_in;
   logic                              phase_b_ff, phase_b_in;
   logic [bfpe_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [bfpe_pkg::PULSE_W-1:0]      pend_ff, pend_in;
   logic                              pend_vld_ff, pend_vld_in;

   logic [bfpe_pkg::PAIR_W-1:0]       pair;
   logic [bfpe_pkg::PULSE_W-1:0]      pulse_a, pulse_b, word;
   logic                              a_def, b_def;
   logic                              end_frame, stall;

   always_comb begin
      pair      = bits_ff[0] ? pulses_for_one : pulses_for_zero;
      pulse_a   = pair[bfpe_pkg::PULSE_W-1:0];
      pulse_b   = pair[bfpe_pkg::PAIR_W-1:bfpe_pkg::PULSE_W];
      a_def     = (pulse_a[bfpe_pkg::DUR_W-1:0] != '0);
      b_def     = (pulse_b[bfpe_pkg::DUR_W-1:0] != '0);
      word      = phase_b_ff ? pulse_b : pulse_a;
      end_frame = (rem_ff == '0) || (!phase_b_ff && !a_def)
               || (cnt_ff == bfpe_pkg::CNT_W'(bfpe_pkg::MAX_RESULTS));
      stall     = pend_vld_ff && out_full;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfpe_pkg::ST_IDLE: begin
            if (!mid_empty) begin
               state_in = bfpe_pkg::ST_RUN;
            end
         end
         bfpe_pkg::ST_RUN: begin
            if (end_frame) begin
               state_in = bfpe_pkg::ST_FLUSH;
            end
         end
         bfpe_pkg::ST_FLUSH: begin
            if (!stall) begin
               state_in = bfpe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfpe_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      bits_in     = bits_ff;
      rem_in      = rem_ff;
      phase_b_in  = phase_b_ff;
      cnt_in      = cnt_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      mid_pop     = 1'b0;
      out_push    = 1'b0;
      out_data.level    = pend_ff[bfpe_pkg::PULSE_W-1];
      out_data.duration = pend_ff[bfpe_pkg::DUR_W-1:0];
      out_data.last     = 1'b0;
      case (state_ff)
         bfpe_pkg::ST_IDLE: begin
            mid_pop     = !mid_empty;
            bits_in     = mid_bits;
            rem_in      = mid_len;
            phase_b_in  = 1'b0;
            cnt_in      = '0;
            pend_vld_in = 1'b0;
         end
         bfpe_pkg::ST_RUN: begin
            if (!end_frame && !stall) begin
               out_push    = pend_vld_ff;
               pend_in     = word;
               pend_vld_in = 1'b1;
               cnt_in      = cnt_ff + bfpe_pkg::CNT_W'(1);
               if (!phase_b_ff && b_def) begin
                  phase_b_in = 1'b1;
               end else begin
                  phase_b_in = 1'b0;
                  bits_in    = bits_ff >> 1;
                  rem_in     = rem_ff - LEN_W'(1);
               end
            end
         end
         bfpe_pkg::ST_FLUSH: begin
            out_data.last = 1'b1;
            if (!stall) begin
               out_push    = pend_vld_ff;
               pend_vld_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bfpe_pkg::ST_IDLE;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
      end
      bits_ff    <= bits_in;
      rem_ff     <= rem_in;
      phase_b_ff <= phase_b_in;
      cnt_ff     <= cnt_in;
      pend_ff    <= pend_in;
   end

endmodule

### rtl/byte_frame_pulse_encoder.sv
// Path: a byte passes the mid queue, the sequencer's frame register and its held-back
// pulse register before its first pulse enters the output queue.
// Throughput: one pulse per cycle while the output queue has room; between bytes the
// sequencer passes its flush and idle states. A full frame holds 25 bits.
// Reset: synchronous, active high; empties queues, clears state and config registers to 0.
// ----------------------------------------------------------------------------
// byte_frame_pulse_encoder
// Frames each data byte and sends it as a stream of pulse descriptors.
// ----------------------------------------------------------------------------
module byte_frame_pulse_encoder #(
   parameter int PREFIX_MAX_BITS  = bfpe_pkg::PREFIX_MAX_BITS,
   parameter int POSTFIX_MAX_BITS = bfpe_pkg::POSTFIX_MAX_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [bfpe_pkg::DATA_BITS-1:0]     req_data_byte,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_pulse_level,
   output logic [bfpe_pkg::DUR_W-1:0]         rsp_pulse_duration,
   output logic                               rsp_last_of_frame,
   input  logic                               csr_write_en,
   input  logic [bfpe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bfpe_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int FRAME_W = PREFIX_MAX_BITS + bfpe_pkg::DATA_BITS + 1 + POSTFIX_MAX_BITS;
   localparam int LEN_W   = $clog2(FRAME_W + 1);

   logic [bfpe_pkg::PATTERN_BITS-1:0] prefix_pattern_ff;
   logic [3:0]                        prefix_length_ff;
   logic [bfpe_pkg::PATTERN_BITS-1:0] postfix_pattern_ff;
   logic [3:0]                        postfix_length_ff;
   logic [2:0]                        frame_mode_ff;
   logic [bfpe_pkg::PAIR_W-1:0]       pulses_for_one_ff;
   logic [bfpe_pkg::PAIR_W-1:0]       pulses_for_zero_ff;

   logic                              mid_push, mid_full, mid_pop, mid_empty;
   logic [FRAME_W-1:0]                mid_bits_wr, mid_bits_rd;
   logic [LEN_W-1:0]                  mid_len_wr, mid_len_rd;
   logic                              out_push, out_full;
   bfpe_pkg::bfpe_pulse_type          out_data, rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_pattern_ff  <= '0;
         prefix_length_ff   <= '0;
         postfix_pattern_ff <= '0;
         postfix_length_ff  <= '0;
         frame_mode_ff      <= '0;
         pulses_for_one_ff  <= '0;
         pulses_for_zero_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            bfpe_pkg::CSR_PREFIX_PATTERN:  prefix_pattern_ff  <= csr_wdata[7:0];
            bfpe_pkg::CSR_PREFIX_LENGTH:   prefix_length_ff   <= csr_wdata[3:0];
            bfpe_pkg::CSR_POSTFIX_PATTERN: postfix_pattern_ff <= csr_wdata[7:0];
            bfpe_pkg::CSR_POSTFIX_LENGTH:  postfix_length_ff  <= csr_wdata[3:0];
            bfpe_pkg::CSR_FRAME_MODE:      frame_mode_ff      <= csr_wdata[2:0];
            bfpe_pkg::CSR_PULSES_ONE:      pulses_for_one_ff  <= csr_wdata;
            bfpe_pkg::CSR_PULSES_ZERO:     pulses_for_zero_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bfpe_front #(
      .PREFIX_MAX_BITS  (PREFIX_MAX_BITS),
      .POSTFIX_MAX_BITS (POSTFIX_MAX_BITS),
      .FRAME_W          (FRAME_W),
      .LEN_W            (LEN_W)
   ) u_front (
      .prefix_pattern  (prefix_pattern_ff),
      .prefix_length   (prefix_length_ff),
      .postfix_pattern (postfix_pattern_ff),
      .postfix_length  (postfix_length_ff),
      .frame_mode      (frame_mode_ff),
      .req_push        (req_push),
      .req_data_byte   (req_data_byte),
      .req_full        (req_full),
      .mid_push        (mid_push),
      .mid_bits        (mid_bits_wr),
      .mid_len         (mid_len_wr),
      .mid_full        (mid_full)
   );

   bfpe_queue #(
      .WIDTH (FRAME_W + LEN_W)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .din   ({mid_bits_wr, mid_len_wr}),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  ({mid_bits_rd, mid_len_rd}),
      .empty (mid_empty)
   );

   bfpe_back #(
      .PREFIX_MAX_BITS  (PREFIX_MAX_BITS),
      .POSTFIX_MAX_BITS (POSTFIX_MAX_BITS),
      .FRAME_W          (FRAME_W),
      .LEN_W            (LEN_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pulses_for_one  (pulses_for_one_ff),
      .pulses_for_zero (pulses_for_zero_ff),
      .mid_empty       (mid_empty),
      .mid_bits        (mid_bits_rd),
      .mid_len         (mid_len_rd),
      .mid_pop         (mid_pop),
      .out_full        (out_full),
      .out_push        (out_push),
      .out_data        (out_data)
   );

   bfpe_queue #(
      .WIDTH ($bits(bfpe_pkg::bfpe_pulse_type))
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (rsp_item),
      .empty (rsp_empty)
   );

   assign rsp_pulse_level    = rsp_item.level;
   assign rsp_pulse_duration = rsp_item.duration;
   assign rsp_last_of_frame  = rsp_item.last;

endmodule

### rtl/bfpe_checker.sv
// ----------------------------------------------------------------------------
// bfpe_checker
// Port-level checks of the byte frame pulse encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfpe_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_full,
   input logic                            rsp_empty,
   input logic                            rsp_pop,
   input logic                            rsp_pulse_level,
   input logic [bfpe_pkg::DUR_W-1:0]      rsp_pulse_duration,
   input logic                            rsp_last_of_frame
);

   logic [bfpe_pkg::DUR_W+1:0] rsp_word;

   assign rsp_word = {rsp_pulse_level, rsp_pulse_duration, rsp_last_of_frame};

   `ASSERT_ALWAYS(a_reset_clears, $past(reset) |-> (rsp_empty && !req_full))
   `ASSERT_CLK(a_duration_nonzero, !rsp_empty |-> (rsp_pulse_duration != '0))
   `ASSERT_CLK(a_rsp_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))

endmodule

bind byte_frame_pulse_encoder bfpe_checker u_bfpe_checker (
   .clock              (clock),
   .reset              (reset),
   .req_full           (req_full),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_pulse_level    (rsp_pulse_level),
   .rsp_pulse_duration (rsp_pulse_duration),
   .rsp_last_of_frame  (rsp_last_of_frame)
);

### tb/byte_frame_pulse_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_frame_pulse_encoder_tb
// Pushes data bytes under a range of register settings and checks every pulse
// descriptor against a frame predictor kept in the bench or against pulses listed
// in the directed plan, with random idling on both the push and the pop side.
// ----------------------------------------------------------------------------
module byte_frame_pulse_encoder_tb;

   localparam int SETTLE_CYCLES = 100;
   localparam int STALL_LIMIT   = 3000;
   localparam logic [bfpe_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef enum logic [1:0] {
      ROW_REG,
      ROW_BYTE,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type                    kind;
      logic [bfpe_pkg::CSR_IDX_W-1:0]  reg_idx;
      logic [bfpe_pkg::CSR_DATA_W-1:0] value;
      logic [5:0]                      count;
      logic                            level;
      logic [bfpe_pkg::DUR_W-1:0]      duration;
   } plan_row_type;

   typedef enum logic [1:0] {
      SETUP_WIDEST,
      SETUP_NARROWEST,
      SETUP_RANDOM
   } setup_kind_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic [bfpe_pkg::DATA_BITS-1:0]  req_data_byte = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic                            rsp_pulse_level;
   logic [bfpe_pkg::DUR_W-1:0]      rsp_pulse_duration;
   logic                            rsp_last_of_frame;
   logic                            csr_write_en = 1'b0;
   logic [bfpe_pkg::CSR_IDX_W-1:0]  csr_index = bfpe_pkg::CSR_PREFIX_PATTERN;
   logic [bfpe_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the register file
   logic [7:0]  cfg_prefix_pattern;
   logic [3:0]  cfg_prefix_len;
   logic [7:0]  cfg_postfix_pattern;
   logic [3:0]  cfg_postfix_len;
   logic [2:0]  cfg_mode;
   logic [31:0] cfg_pulses_one;
   logic [31:0] cfg_pulses_zero;

   bfpe_pkg::bfpe_pulse_type pulse_expect_q[$];
   plan_row_type             dir_plan[$];
   int                       mismatch_count = 0;
   int                       send_idle_pct = 0;
   int                       recv_idle_pct = 0;
   int                       idle_cycles = 0;
   bit                       csr_open = 1'b0;

   byte_frame_pulse_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_pulse_level    (rsp_pulse_level),
      .rsp_pulse_duration (rsp_pulse_duration),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // builds the frame bit by bit and queues the pulses it turns into
   function automatic void frame_expect(input logic [7:0] d);
      logic                     frame_bits[$];
      int                       pre_n;
      int                       post_n;
      logic [1:0]               par;
      logic [31:0]              pair;
      logic [15:0]              w;
      int                       emitted;
      logic                     stopped;
      bfpe_pkg::bfpe_pulse_type p;
      pre_n  = (cfg_prefix_len > bfpe_pkg::PREFIX_MAX_BITS) ?
               bfpe_pkg::PREFIX_MAX_BITS : cfg_prefix_len;
      post_n = (cfg_postfix_len > bfpe_pkg::POSTFIX_MAX_BITS) ?
               bfpe_pkg::POSTFIX_MAX_BITS : cfg_postfix_len;
      for (int i = 0; i < pre_n; i++)
         frame_bits.push_back((i < bfpe_pkg::PATTERN_BITS) ? cfg_prefix_pattern[i] : 1'b0);
      for (int i = 0; i < bfpe_pkg::DATA_BITS; i++)
         frame_bits.push_back(cfg_mode[0] ? d[bfpe_pkg::DATA_BITS-1-i] : d[i]);
      par = cfg_mode[2:1];
      if (par != bfpe_pkg::PAR_NONE)
         frame_bits.push_back((par == bfpe_pkg::PAR_EVEN) ? ^d : ~^d);
      for (int i = 0; i < post_n; i++)
         frame_bits.push_back((i < bfpe_pkg::PATTERN_BITS) ? cfg_postfix_pattern[i] : 1'b0);
      emitted = 0;
      stopped = 1'b0;
      foreach (frame_bits[i]) begin
         pair = frame_bits[i] ? cfg_pulses_one : cfg_pulses_zero;
         if (!stopped && pair[14:0] == '0) begin
            stopped = 1'b1;
         end else if (!stopped) begin
            for (int k = 0; k < 2; k++) begin
               w = k ? pair[31:16] : pair[15:0];
               if (w[14:0] != '0 && !stopped) begin
                  if (emitted >= bfpe_pkg::MAX_RESULTS) begin
                     stopped = 1'b1;
                  end else begin
                     p.level    = w[15];
                     p.duration = w[14:0];
                     p.last     = 1'b0;
                     pulse_expect_q.push_back(p);
                     emitted++;
                  end
               end
            end
         end
      end
      if (emitted > 0) begin
         p = pulse_expect_q.pop_back();
         p.last = 1'b1;
         pulse_expect_q.push_back(p);
      end
   endfunction

   function automatic logic [15:0] rand_word(input int undef_pct);
      logic [14:0] dur;
      if ($urandom_range(0, 99) < undef_pct)
         dur = '0;
      else
         case ($urandom_range(0, 3))
            0:       dur = 15'($urandom_range(1, 15));
            1:       dur = 15'h7FFF;
            default: dur = 15'($urandom_range(1, 32767));
         endcase
      return {1'($urandom_range(0, 1)), dur};
   endfunction

   function automatic logic [31:0] rand_len();
      if ($urandom_range(0, 4) == 0)
         return ($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 15);
      return $urandom_range(0, 9);
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      req_push <= 1'b0;
      while (pulse_expect_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic reg_write(input logic [bfpe_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] val);
      if (!csr_open) begin
         wait_drained();
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      case (idx)
         bfpe_pkg::CSR_PREFIX_PATTERN:  cfg_prefix_pattern  = val[7:0];
         bfpe_pkg::CSR_PREFIX_LENGTH:   cfg_prefix_len      = val[3:0];
         bfpe_pkg::CSR_POSTFIX_PATTERN: cfg_postfix_pattern = val[7:0];
         bfpe_pkg::CSR_POSTFIX_LENGTH:  cfg_postfix_len     = val[3:0];
         bfpe_pkg::CSR_FRAME_MODE:      cfg_mode            = val[2:0];
         bfpe_pkg::CSR_PULSES_ONE:      cfg_pulses_one      = val;
         bfpe_pkg::CSR_PULSES_ZERO:     cfg_pulses_zero     = val;
         default: ;
      endcase
      csr_open = 1'b1;
   endtask

   task automatic send_byte(input logic [7:0] d, input logic typed, input int n,
                            input logic lvl, input logic [bfpe_pkg::DUR_W-1:0] dur);
      bfpe_pkg::bfpe_pulse_type p;
      if (csr_open) begin
         @(negedge clock);
         csr_write_en <= 1'b0;
         csr_open = 1'b0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_push      <= 1'b1;
      req_data_byte <= d;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      if (typed) begin
         for (int k = 0; k < n; k++) begin
            p.level    = lvl;
            p.duration = dur;
            p.last     = (k == n - 1);
            pulse_expect_q.push_back(p);
         end
      end else begin
         frame_expect(d);
      end
   endtask

   task automatic random_setup(input setup_kind_type style);
      logic [31:0] pre_len;
      logic [31:0] post_len;
      logic [31:0] mode;
      logic [31:0] one_w;
      logic [31:0] zero_w;
      case (style)
         SETUP_WIDEST: begin
            pre_len  = $urandom_range(8, 15);
            post_len = $urandom_range(8, 15);
            mode     = $urandom_range(2, 7);
            one_w    = {rand_word(0), rand_word(0)};
            zero_w   = {rand_word(0), rand_word(0)};
         end
         SETUP_NARROWEST: begin
            pre_len  = 0;
            post_len = 0;
            mode     = $urandom_range(0, 1);
            one_w    = {rand_word(100), rand_word(0)};
            zero_w   = {rand_word(50), rand_word(0)};
         end
         default: begin
            pre_len  = rand_len();
            post_len = rand_len();
            mode     = $urandom;
            one_w    = {rand_word(30), rand_word(8)};
            zero_w   = {rand_word(30), rand_word(8)};
         end
      endcase
      reg_write(bfpe_pkg::CSR_PREFIX_PATTERN, $urandom);
      reg_write(bfpe_pkg::CSR_PREFIX_LENGTH, pre_len);
      reg_write(bfpe_pkg::CSR_POSTFIX_PATTERN, $urandom);
      reg_write(bfpe_pkg::CSR_POSTFIX_LENGTH, post_len);
      reg_write(bfpe_pkg::CSR_FRAME_MODE, mode);
      reg_write(bfpe_pkg::CSR_PULSES_ONE, one_w);
      reg_write(bfpe_pkg::CSR_PULSES_ZERO, zero_w);
   endtask

   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      bfpe_pkg::bfpe_pulse_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pulse_expect_q.size() == 0) begin
            $display("%0t: unexpected pulse: level=%0d duration=%0d last=%0d", $time,
                     rsp_pulse_level, rsp_pulse_duration, rsp_last_of_frame);
            mismatch_count++;
         end else begin
            want = pulse_expect_q.pop_front();
            if (rsp_pulse_level !== want.level) begin
               $display("%0t: pulse_level expected %0d actual %0d", $time,
                        want.level, rsp_pulse_level);
               mismatch_count++;
            end
            if (rsp_pulse_duration !== want.duration) begin
               $display("%0t: pulse_duration expected %0d actual %0d", $time,
                        want.duration, rsp_pulse_duration);
               mismatch_count++;
            end
            if (rsp_last_of_frame !== want.last) begin
               $display("%0t: last_of_frame expected %0d actual %0d", $time,
                        want.last, rsp_last_of_frame);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on transactions of any kind
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_write_en) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d pulses outstanding", $time, pulse_expect_q.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      plan_row_type row;
      logic [7:0] b;
      int sel;
      cfg_prefix_pattern  = '0;
      cfg_prefix_len      = '0;
      cfg_postfix_pattern = '0;
      cfg_postfix_len     = '0;
      cfg_mode            = '0;
      cfg_pulses_one      = '0;
      cfg_pulses_zero     = '0;
      dir_plan = '{
         '{ROW_TYPED, CSR_SPARE,                     32'h0000_00A5, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PULSES_ONE,      32'h0000_FFFF, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PULSES_ZERO,     32'h0000_0001, 6'd0,  1'b0, 15'd0},
         '{ROW_TYPED, CSR_SPARE,                     32'h0000_00FF, 6'd8,  1'b1, 15'h7FFF},
         '{ROW_TYPED, CSR_SPARE,                     32'h0000_0000, 6'd8,  1'b0, 15'd1},
         '{ROW_REG,   bfpe_pkg::CSR_PULSES_ZERO,     32'h0000_8000, 6'd0,  1'b0, 15'd0},
         '{ROW_TYPED, CSR_SPARE,                     32'h0000_0000, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_000F, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_FRAME_MODE,      32'h0000_0001, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_00F0, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_0080, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PULSES_ZERO,     32'hFFFF_8001, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PULSES_ONE,      32'h8000_7FFF, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PREFIX_PATTERN,  32'hFFFF_FFA5, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PREFIX_LENGTH,   32'h0000_0008, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_POSTFIX_PATTERN, 32'h0000_003C, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_POSTFIX_LENGTH,  32'hFFFF_FFFF, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_FRAME_MODE,      32'h0000_0002, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_0001, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_0000, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_FRAME_MODE,      32'h0000_0005, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_007E, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_FRAME_MODE,      32'h0000_0007, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_0081, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PREFIX_LENGTH,   32'h0000_000F, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   CSR_SPARE,                     32'hFFFF_FFFF, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_0055, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PULSES_ONE,      32'hFFFF_FFFF, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PULSES_ZERO,     32'hFFFF_FFFF, 6'd0,  1'b0, 15'd0},
         '{ROW_TYPED, CSR_SPARE,                     32'h0000_00C3, 6'd50, 1'b1, 15'h7FFF},
         '{ROW_REG,   bfpe_pkg::CSR_PULSES_ZERO,     32'h0000_0000, 6'd0,  1'b0, 15'd0},
         '{ROW_BYTE,  CSR_SPARE,                     32'h0000_00FF, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_PREFIX_LENGTH,   32'h0000_0000, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_POSTFIX_LENGTH,  32'h0000_0000, 6'd0,  1'b0, 15'd0},
         '{ROW_REG,   bfpe_pkg::CSR_FRAME_MODE,      32'h0000_0000, 6'd0,  1'b0, 15'd0},
         '{ROW_TYPED, CSR_SPARE,                     32'h0000_0000, 6'd0,  1'b0, 15'd0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 14;
      recv_idle_pct = 85;
      foreach (dir_plan[i]) begin
         row = dir_plan[i];
         case (row.kind)
            ROW_REG:   reg_write(row.reg_idx, row.value);
            ROW_BYTE:  send_byte(row.value[7:0], 1'b0, 0, 1'b0, '0);
            default:   send_byte(row.value[7:0], 1'b1, row.count, row.level, row.duration);
         endcase
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 85 : 0;
         recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 14 : 0;
         for (int round = 0; round < 4; round++) begin
            random_setup((round == 0) ? SETUP_WIDEST :
                         (round == 1) ? SETUP_NARROWEST : SETUP_RANDOM);
            for (int j = 0; j < 10; j++) begin
               if (round == 2 && j == 5)
                  wait_drained();
               sel = $urandom_range(0, 9);
               b = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom_range(0, 255));
               send_byte(b, 1'b0, 0, 1'b0, '0);
            end
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
